// ===== design/assert_macros.svh =====
// Assertion helpers. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== design/stbs_pkg.sv =====
`timescale 1ns / 1ps
package stbs_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int KEY_W = 64;
    localparam int PAY_W = 64;

    // opcodes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] lat_bits;
        logic [PAY_W-1:0] lon_bits;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [PAY_W-1:0] found_lat;
        logic [PAY_W-1:0] found_lon;
    } rsp_t;

    // one table row as held in the RAM
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] lat;
        logic [PAY_W-1:0] lon;
    } entry_t;

    typedef struct packed {
        logic hit;
        logic exhausted;
    } probe_flags_t;

endpackage

// ===== design/stbs_ram.sv =====
`timescale 1ns / 1ps
module stbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/stbs_probe.sv =====
`timescale 1ns / 1ps
module stbs_probe import stbs_pkg::*; #(
    parameter int AW = 10,
    parameter int CW = 11
) (
    input  logic [CW-1:0]    lo,
    input  logic [CW-1:0]    hi,
    input  logic [AW-1:0]    mid,
    input  logic [KEY_W-1:0] entry_key,
    input  logic [KEY_W-1:0] key,
    output logic [CW-1:0]    lo_next,
    output logic [CW-1:0]    hi_next,
    output logic [AW-1:0]    mid_next,
    output probe_flags_t     flags
);

    logic          less;
    logic [CW-1:0] mid_ext;
    logic [CW-1:0] span;
    logic [CW-1:0] mid_full;

    // one search step: compare, narrow the window, form the next midpoint
    always_comb
    begin
        less     = entry_key < key;
        mid_ext  = CW'(mid);
        lo_next  = less ? (mid_ext + CW'(1)) : lo;
        hi_next  = less ? hi : mid_ext;
        span     = hi_next - lo_next;
        mid_full = lo_next + (span >> 1);
        mid_next = mid_full[AW-1:0];
        flags.hit       = entry_key == key;
        flags.exhausted = lo_next >= hi_next;
    end

endmodule

// ===== design/sorted_table_binary_search_unit.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid / req_stall  | req_t : op, key, lat_bits, lon_bits
// rsp     | out       | rsp_valid / rsp_stall  | rsp_t : status, found_lat, found_lon
//
// Append: accepted, result ready in the result register in the next cycle.
// Lookup: window and key are loaded at acceptance, then one probe per cycle,
//   at most ceil(log2(count + 1)) probes (11 at 1024 entries), set by the single
//   table read port feeding one compare-and-halve step.
// A request is taken only while idle; a finished result may wait in the
//   output register while the next request is accepted.
// Reset clears the state, the entry count and the response valid flag; the table itself needs no clearing.
`include "assert_macros.svh"
module sorted_table_binary_search_unit import stbs_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_PROBE = 3'b010,
        S_DONE  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    hi_reg, hi_next;
    logic [AW-1:0]    mid_reg, mid_next;
    logic [KEY_W-1:0] key_reg, key_next;
    rsp_t             res_reg, res_next;
    rsp_t             rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic             req_fire;
    logic             out_free;
    logic             table_full;
    logic [AW-1:0]    first_mid;

    // table RAM
    logic             wr_en;
    logic [AW-1:0]    rd_addr;
    logic [$bits(entry_t)-1:0] rd_data;
    entry_t           entry_rd;
    entry_t           entry_wr;

    // probe step
    logic [CW-1:0]    step_lo;
    logic [CW-1:0]    step_hi;
    logic [AW-1:0]    step_mid;
    probe_flags_t     step_flags;

    assign req_stall = state_reg != S_IDLE;
    assign req_fire  = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign table_full = count_reg == CW'(TABLE_DEPTH);
    assign first_mid = AW'(count_reg >> 1);

    assign entry_wr.key = req.key;
    assign entry_wr.lat = req.lat_bits;
    assign entry_wr.lon = req.lon_bits;
    assign wr_en = req_fire && (req.op == OP_APPEND) && !table_full;
    assign entry_rd = entry_t'(rd_data);

    // While idle, pre-read the first midpoint so a lookup probes next cycle.
    assign rd_addr = (state_reg == S_PROBE) ? step_mid : first_mid;

    stbs_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (entry_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    stbs_probe #(
        .AW (AW),
        .CW (CW)
    ) u_probe (
        .lo        (lo_reg),
        .hi        (hi_reg),
        .mid       (mid_reg),
        .entry_key (entry_rd.key),
        .key       (key_reg),
        .lo_next   (step_lo),
        .hi_next   (step_hi),
        .mid_next  (step_mid),
        .flags     (step_flags)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    res_next.found_lat = '0;
                    res_next.found_lon = '0;
                    if (req.op == OP_APPEND)
                    begin
                        state_next = S_DONE;
                        if (table_full)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            res_next.status = ST_OK;
                            count_next      = count_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        key_next = req.key;
                        lo_next  = '0;
                        hi_next  = count_reg;
                        mid_next = first_mid;
                        if (count_reg == '0)
                        begin
                            res_next.status = ST_MISS;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_PROBE;
                        end
                    end
                end
            end
            S_PROBE:
            begin
                if (step_flags.hit)
                begin
                    res_next.status    = ST_OK;
                    res_next.found_lat = entry_rd.lat;
                    res_next.found_lon = entry_rd.lon;
                    state_next         = S_DONE;
                end
                else if (step_flags.exhausted)
                begin
                    res_next.status    = ST_MISS;
                    res_next.found_lat = '0;
                    res_next.found_lon = '0;
                    state_next         = S_DONE;
                end
                else
                begin
                    lo_next  = step_lo;
                    hi_next  = step_hi;
                    mid_next = step_mid;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // search window and result payload
    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        key_reg <= key_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(TABLE_DEPTH), "entry count above depth")
    `ASSERT_IMPLY(a_window_open, state_reg == S_PROBE, (lo_reg < hi_reg) && (CW'(mid_reg) >= lo_reg) && (CW'(mid_reg) < hi_reg), "probe outside search window")
    `ASSERT_IMPLY(a_status_code, rsp_valid_reg, (rsp_reg.status == ST_OK) || (rsp_reg.status == ST_MISS) || (rsp_reg.status == ST_FULL), "bad status code")
    `ASSERT_NEXT(a_append_count, wr_en, count_reg == $past(count_reg) + CW'(1), "append lost")
    `ASSERT_IMPLY(a_probe_in_table, state_reg == S_PROBE, CW'(mid_reg) < count_reg, "probe beyond filled entries")

endmodule
